// ----- design/mmhh_pkg.sv -----
// ----------------------------------------------------------------------------
// mmhh_pkg: shared types and constants for the mecanum mixer
// Payload structs, command codes, datapath widths and small helpers.
// ----------------------------------------------------------------------------
package mmhh_pkg;

  localparam logic [1:0] CMD_DRIVE  = 2'd0;
  localparam logic [1:0] CMD_ROTATE = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  localparam logic [14:0] GAIN_RESET = 15'd1638;

  // Wheel sums can reach about 2^37 when the heading error is large.
  localparam int WHEEL_W = 42;
  localparam int MAG_W   = WHEEL_W - 1;
  localparam int QUO_W   = 16;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic signed [31:0] gyro_angle;
    logic signed [15:0] forward_cmd;
    logic signed [15:0] turn_cmd;
    logic signed [15:0] strafe_cmd;
    logic signed [31:0] rotate_angle;
    logic               rotate_reverse;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] motor_one;
    logic signed [15:0] motor_two;
    logic signed [15:0] motor_three;
    logic signed [15:0] motor_four;
    logic signed [31:0] heading_error;
  } out_item_t;

  typedef logic signed [WHEEL_W-1:0] wheel_t;

  function automatic logic [MAG_W-1:0] wheel_mag(input wheel_t v);
    wheel_t a;
    a = v[WHEEL_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input wheel_t v);
    logic signed [15:0] r;
    if (v > $signed(42'sd32767)) begin
      r = 16'sh7fff;
    end else if (v < $signed(-42'sd32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- design/mmhh_div.sv -----
// ----------------------------------------------------------------------------
// mmhh_div: iterative wheel normalizer
// Computes floor(num * 2^15 / den) for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mmhh_div
  import mmhh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [MAG_W-1:0]        num,
  input  logic [MAG_W-1:0]        den,
  output logic                    done,
  output logic [QUO_W-1:0]        quo
);

  logic             busy_r, busy_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [MAG_W:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [MAG_W-1:0] den_r, den_nxt;
  logic             done_r, done_nxt;

  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] diff;

  always_comb begin
    // The first step tests the remainder itself, since the quotient can be 2^15.
    shifted  = (cnt_r == 4'd0) ? rem_r : {rem_r[MAG_W-1:0], 1'b0};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      rem_nxt  = {1'b0, num};
      quo_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!diff[MAG_W+1]) begin
        rem_nxt = diff[MAG_W:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- design/mecanum_mixer_heading_hold.sv -----
// ----------------------------------------------------------------------------
// mecanum_mixer_heading_hold: mecanum wheel mixer with gyro heading hold
// Mixes forward, turn and strafe demands into four motor values.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one command per
//   transfer. A drive command yields one result on the output channel
//   (out_valid, out_stall, out_data); stop yields one all-zero result;
//   rotate only moves the stored heading zero and yields nothing.
//   cfg_we/cfg_wdata write the heading gain; write it only while idle.
//
//   A drive item runs the multiply, mix, maximum search and check steps; when
//   a wheel exceeds full scale, the shared bit-serial divider then normalizes
//   the four wheels one after another. Stop goes straight to the output state
//   and rotate never leaves idle. in_stall is high for the whole time an item
//   is worked.
//
//   The result sits in an output register, so the block takes the next item
//   while a result waits. If the receiver stalls and a second result is
//   ready, the sequencer holds until the register frees.
//   Reset clears the heading zero, restores the default gain and drops
//   out_valid.
module mecanum_mixer_heading_hold
  import mmhh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_MIX    = 3'd2;
  localparam logic [2:0] S_MAX    = 3'd3;
  localparam logic [2:0] S_CHK    = 3'd4;
  localparam logic [2:0] S_DSTART = 3'd5;
  localparam logic [2:0] S_DWAIT  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(32768);

  logic [2:0]         state_r, state_nxt;
  logic [14:0]        gain_r;
  logic signed [31:0] zero_r, zero_nxt;
  in_item_t           item_r, item_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic               stop_r, stop_nxt;
  logic signed [47:0] prod_r, prod_nxt;
  wheel_t             wheel_r [4];
  wheel_t             wheel_nxt [4];
  logic [1:0]         idx_r, idx_nxt;
  logic [MAG_W-1:0]   max_r, max_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               in_fire;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [MAG_W-1:0]   cur_mag;

  logic signed [47:0] corr_w, tdiff_w, t_w;
  wheel_t             t42, fwd42, str42, q42;

  assign in_fire  = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cur_mag  = wheel_mag(wheel_r[idx_r]);

  mmhh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (cur_mag),
    .den   (max_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    zero_nxt      = zero_r;
    item_nxt      = item_r;
    err_nxt       = err_r;
    stop_nxt      = stop_r;
    prod_nxt      = prod_r;
    wheel_nxt     = wheel_r;
    idx_nxt       = idx_r;
    max_nxt       = max_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;

    corr_w  = prod_r >>> 8;
    tdiff_w = $signed({{32{item_r.turn_cmd[15]}}, item_r.turn_cmd}) - corr_w;
    t_w     = tdiff_w >>> 1;
    t42     = t_w[WHEEL_W-1:0];
    fwd42   = -$signed({{(WHEEL_W-16){item_r.forward_cmd[15]}}, item_r.forward_cmd});
    str42   = $signed({{(WHEEL_W-16){item_r.strafe_cmd[15]}}, item_r.strafe_cmd});
    q42     = $signed({{(WHEEL_W-QUO_W){1'b0}}, div_quo});

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          err_nxt  = in_data.gyro_angle - zero_r;
          case (in_data.cmd)
            CMD_DRIVE: begin
              // The error for this item is taken before the zero moves.
              if (in_data.turn_cmd != 16'sd0) begin
                zero_nxt = in_data.gyro_angle;
              end
              stop_nxt  = 1'b0;
              state_nxt = S_MUL;
            end
            CMD_ROTATE: begin
              zero_nxt = in_data.rotate_reverse ?
                         in_data.gyro_angle - in_data.rotate_angle :
                         in_data.gyro_angle + in_data.rotate_angle;
            end
            CMD_STOP: begin
              stop_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = err_r * $signed({1'b0, gain_r});
        state_nxt = S_MIX;
      end
      S_MIX: begin
        wheel_nxt[0] = fwd42 + t42 + str42;
        wheel_nxt[1] = fwd42 - t42 - str42;
        wheel_nxt[2] = fwd42 + t42 - str42;
        wheel_nxt[3] = fwd42 - t42 + str42;
        idx_nxt      = 2'd0;
        max_nxt      = '0;
        state_nxt    = S_MAX;
      end
      S_MAX: begin
        if (cur_mag > max_r) begin
          max_nxt = cur_mag;
        end
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        idx_nxt   = 2'd0;
        state_nxt = (max_r > FULL_SCALE) ? S_DSTART : S_FIN;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          wheel_nxt[idx_r] = wheel_r[idx_r][WHEEL_W-1] ? -q42 : q42;
          idx_nxt          = idx_r + 2'd1;
          state_nxt        = (idx_r == 2'd3) ? S_FIN : S_DSTART;
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (stop_r) begin
            out_nxt = '0;
          end else begin
            out_nxt.motor_one     = sat16(wheel_r[3]);
            out_nxt.motor_two     = sat16(wheel_r[1]);
            out_nxt.motor_three   = sat16(-wheel_r[2]);
            out_nxt.motor_four    = sat16(-wheel_r[0]);
            out_nxt.heading_error = err_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gain_r      <= GAIN_RESET;
      zero_r      <= '0;
      out_valid_r <= 1'b0;
      stop_r      <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
      stop_r      <= stop_nxt;
      idx_r       <= idx_nxt;
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
    end
    item_r  <= item_nxt;
    err_r   <= err_nxt;
    prod_r  <= prod_nxt;
    wheel_r <= wheel_nxt;
    max_r   <= max_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/mmhh_check.sv -----
// ----------------------------------------------------------------------------
// mmhh_check: port-level checks for the mecanum mixer
// Watches the handshakes and the busy behavior seen at the top level.
// ----------------------------------------------------------------------------
module mmhh_check
  import mmhh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data
);

  logic drive_or_stop_fire;
  assign drive_or_stop_fire = in_valid && !in_stall &&
                              (in_data.cmd == CMD_DRIVE || in_data.cmd == CMD_STOP);

  // A stalled result transfer keeps its valid.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An item that produces a result keeps the block busy next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    drive_or_stop_fire |=> in_stall)
    else $error("input taken while an item is in progress");

  // A drive item needs at least the multiply and mix cycles before its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == CMD_DRIVE
    |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("drive result appeared too early");

endmodule

bind mecanum_mixer_heading_hold mmhh_check u_mmhh_check (.*);

// ----- bench/mecanum_mixer_heading_hold_tb.sv -----
// ----------------------------------------------------------------------------
// mecanum_mixer_heading_hold_tb: self-checking bench for the mecanum mixer
// Drives drive, rotate, stop and unused commands through the input channel
// with random gaps and output stalls, predicts every result in the bench and
// compares each one against the oldest prediction, across several gains.
// ----------------------------------------------------------------------------
module mecanum_mixer_heading_hold_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmhh_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int PHASE_ITEMS   = 270;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    in_item_t   item;
    logic [7:0] gap;
  } pending_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [14:0] cfg_wdata = '0;

  // Bench copy of the block state and gain.
  logic [31:0] zero_track = '0;
  logic [14:0] gain_track = GAIN_RESET;

  pending_t    cmd_backlog[$];
  out_item_t   motor_due[$];
  pending_t    next_entry;
  out_item_t   predicted;
  logic [7:0]  tx_gap    = '0;
  logic [31:0] gyro_walk = '0;
  int          sent_count   = 0;
  int          result_count = 0;
  int          mismatches   = 0;
  int          cycle_count  = 0;
  int          rx_left      = 0;
  logic [9:0]  rx_cycle     = '0;
  logic        rx_hold      = 1'b0;

  mecanum_mixer_heading_hold dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [15:0] clip_q15(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit mix_wheels(input in_item_t it, output out_item_t res);
    longint      fwd, trn, str, err, corr, t, fl, fr, rl, rr, m;
    logic [31:0] err_u;
    bit          has;
    res = '0;
    has = 1'b0;
    case (it.cmd)
      CMD_ROTATE: begin
        if (it.rotate_reverse) zero_track = it.gyro_angle - it.rotate_angle;
        else zero_track = it.gyro_angle + it.rotate_angle;
      end
      CMD_STOP: begin
        has = 1'b1;
      end
      CMD_DRIVE: begin
        has = 1'b1;
        fwd = -longint'($signed(it.forward_cmd));
        trn = longint'($signed(it.turn_cmd));
        str = longint'($signed(it.strafe_cmd));
        err_u = it.gyro_angle - zero_track;
        err = longint'($signed(err_u));
        // Arithmetic shifts of signed values floor toward minus infinity.
        corr = (err * longint'(gain_track)) >>> 8;
        t = (trn - corr) >>> 1;
        fl = fwd + t + str;
        fr = fwd - t - str;
        rl = fwd + t - str;
        rr = fwd - t + str;
        m = mag64(fl);
        if (mag64(fr) > m) m = mag64(fr);
        if (mag64(rl) > m) m = mag64(rl);
        if (mag64(rr) > m) m = mag64(rr);
        if (m > 32768) begin
          fl = fl * 32768 / m;
          fr = fr * 32768 / m;
          rl = rl * 32768 / m;
          rr = rr * 32768 / m;
        end
        if (trn != 0) zero_track = it.gyro_angle;
        res.motor_one     = clip_q15(rr);
        res.motor_two     = clip_q15(fr);
        res.motor_three   = clip_q15(-rl);
        res.motor_four    = clip_q15(-fl);
        res.heading_error = err_u;
      end
      default: begin
        has = 1'b0;
      end
    endcase
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_item_t cmd_item(input logic [1:0] c, input logic [31:0] g,
                                        input logic [15:0] f, input logic [15:0] tr,
                                        input logic [15:0] s, input logic [31:0] a,
                                        input logic rev);
    in_item_t it;
    it.cmd            = c;
    it.gyro_angle     = g;
    it.forward_cmd    = f;
    it.turn_cmd       = tr;
    it.strafe_cmd     = s;
    it.rotate_angle   = a;
    it.rotate_reverse = rev;
    return it;
  endfunction

  function automatic logic [7:0] pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'd0;
    if (r < 88) return 8'($urandom_range(1, 3));
    if (r < 97) return 8'($urandom_range(4, 12));
    return 8'($urandom_range(20, 60));
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 94) return $urandom_range(0, 2);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [15:0] rand_q15();
    logic [15:0] v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 3))
        0:       v = 16'h8000;
        1:       v = 16'h7fff;
        2:       v = 16'h0000;
        default: v = 16'hffff;
      endcase
    end else if (r < 60) begin
      v = 16'($urandom_range(0, 8192) - 4096);
    end else begin
      v = 16'($urandom);
    end
    return v;
  endfunction

  // Most drive items follow a slowly wandering heading so the hold loop sees
  // realistic errors; the rest carry a fully random reading.
  function automatic in_item_t rand_item();
    in_item_t     it;
    logic [127:0] raw;
    int unsigned  r;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    r = $urandom_range(0, 99);
    if (r < 70) begin
      it.cmd = CMD_DRIVE;
      if ($urandom_range(0, 3) != 0) begin
        gyro_walk = gyro_walk + $urandom_range(0, 2000) - 1000;
        it.gyro_angle = gyro_walk;
      end
      it.forward_cmd = rand_q15();
      it.strafe_cmd  = rand_q15();
      it.turn_cmd    = ($urandom_range(0, 99) < 45) ? 16'h0000 : rand_q15();
    end else if (r < 82) begin
      it.cmd = CMD_ROTATE;
      if ($urandom_range(0, 3) != 0) it.gyro_angle = gyro_walk;
      if ($urandom_range(0, 9) < 7) it.rotate_angle = $urandom_range(0, 40000) - 20000;
    end else if (r < 94) begin
      it.cmd = CMD_STOP;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it, input bit calm);
    pending_t e;
    e.item = it;
    e.gap  = calm ? 8'd0 : pick_gap();
    cmd_backlog.push_back(e);
  endtask

  task automatic load_random(input int n);
    for (int k = 0; k < n; k++) offer(rand_item(), ((k / 50) % 4) == 3);
  endtask

  task automatic settle();
    while (cmd_backlog.size() != 0 || in_valid || motor_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [14:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    gain_track = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one transfer per accepted item, then the gap chosen for it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        sent_count <= sent_count + 1;
        if (mix_wheels(in_data, predicted)) motor_due.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 8'd1;
        end else if (cmd_backlog.size() != 0) begin
          next_entry = cmd_backlog.pop_front();
          in_data  <= next_entry.item;
          in_valid <= 1'b1;
          tx_gap   <= next_entry.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer and drives random output stalls.
  // --------------------------------------------------------------------------
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (motor_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result %0d: motors %0d %0d %0d %0d error %0d", result_count,
                 got.motor_one, got.motor_two, got.motor_three, got.motor_four,
                 got.heading_error);
    end else begin
      want = motor_due.pop_front();
      if (got.motor_one !== want.motor_one || got.motor_two !== want.motor_two ||
          got.motor_three !== want.motor_three || got.motor_four !== want.motor_four ||
          got.heading_error !== want.heading_error) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result %0d: expected %0d %0d %0d %0d error %0d, got %0d %0d %0d %0d error %0d",
                   result_count, want.motor_one, want.motor_two, want.motor_three,
                   want.motor_four, want.heading_error, got.motor_one, got.motor_two,
                   got.motor_three, got.motor_four, got.heading_error);
      end
    end
    result_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_left   <= 0;
      rx_cycle  <= '0;
    end else begin
      rx_cycle <= rx_cycle + 10'd1;
      if (out_valid && !out_stall) check_result(out_data);
      // One window in four runs without random stalls.
      if (rx_left != 0) begin
        rx_left   <= rx_left - 1;
        out_stall <= 1'b1;
      end else if (rx_cycle[9:8] != 2'b11 && $urandom_range(0, 99) < 25) begin
        rx_left   <= pick_stall();
        out_stall <= 1'b1;
      end else begin
        out_stall <= rx_hold;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the output
  // register fills and the block backs up onto its input.
  initial begin
    while (sent_count < 120) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [14:0] gain_plan [5];
    gain_plan[0] = 15'd0;
    gain_plan[1] = 15'd32767;
    gain_plan[2] = 15'd1;
    gain_plan[3] = 15'($urandom_range(2, 32766));
    gain_plan[4] = GAIN_RESET;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, default gain, heading zero starts at 0.
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    // Full-scale wheel: forward of -1.0 gives wheels of exactly +1.0.
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h8000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h7fff, 16'h0000, 16'h8000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h8000, 16'h8000, 16'h8000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h0000, 16'h0000, 16'h7fff, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd1000, 16'h0000, 16'h7fff, 16'h0000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd1256, 16'h0400, 16'h0000, 16'hfc00, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'h7fffffff, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    // Error wrap around the 32-bit heading circle.
    offer(cmd_item(CMD_ROTATE, 32'd0, 16'h1234, 16'h5678, 16'h9abc, 32'h80000000, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'h7fffffff, 16'h0100, 16'h0000, 16'h0100, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_ROTATE, 32'h7fffffff, 16'h0000, 16'h0000, 16'h0000, 32'd1, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_ROTATE, 32'd100, 16'h0000, 16'h0000, 16'h0000, 32'h7fffffff, 1'b1),
          1'b0);
    offer(cmd_item(CMD_DRIVE, 32'hffff8000, 16'h7fff, 16'h0000, 16'h7fff, 32'd0, 1'b0), 1'b0);
    // Stop returns zeros and leaves the heading zero alone.
    offer(cmd_item(CMD_STOP, 32'hdeadbeef, 16'h7fff, 16'h8000, 16'h7fff, 32'h7fffffff, 1'b1),
          1'b0);
    // The unused selector must not recapture the heading zero.
    offer(cmd_item(CMD_UNUSED, 32'h12345678, 16'h8000, 16'h7fff, 16'h8000, 32'h80000000, 1'b1),
          1'b0);
    offer(cmd_item(CMD_DRIVE, 32'hffff8000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_ROTATE, 32'd500, 16'h0000, 16'h0000, 16'h0000, 32'd500, 1'b1), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'hffff, 16'hffff, 16'hffff, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h0001, 16'h0001, 16'h0001, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_STOP, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0), 1'b0);
    offer(cmd_item(CMD_ROTATE, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'h80000000, 1'b1), 1'b0);
    offer(cmd_item(CMD_DRIVE, 32'd0, 16'h2000, 16'h0000, 16'he000, 32'd0, 1'b0), 1'b0);
    load_random(PHASE_ITEMS);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_gain(gain_plan[p]);
      load_random(PHASE_ITEMS);
    end
    settle();

    if (mismatches == 0 && motor_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (motor_due.size() != 0)
        $display("%0d expected results never arrived", motor_due.size());
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
